FILE: sv/eeg_pkg.sv
// ---------------------------------------------------------------------------
// eeg_pkg
// Shared types and constants for the extended Euclid GCD core.
// ---------------------------------------------------------------------------
`default_nettype none

package eeg_pkg;

   localparam int STEP_WIDTH = 7;

   // Quotient bit stream from the serial divider to the coefficient lanes.
   typedef struct packed {
      logic start;   // new division, clear accumulators
      logic shift;   // qbit is valid this cycle
      logic qbit;    // quotient bit, MSB first
      logic last;    // final quotient bit
   } eeg_qstream_type;

endpackage

`default_nettype wire

FILE: sv/eeg_divider.sv
// ---------------------------------------------------------------------------
// eeg_divider
// Restoring serial divider, one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module eeg_divider
   import eeg_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [OPERAND_WIDTH-1:0] dividend,
   input  wire logic [OPERAND_WIDTH-1:0] divisor,
   output eeg_qstream_type               qstream,
   output logic      [OPERAND_WIDTH-1:0] remainder
);

   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] dvd_ff, dvd_in;
   logic [OPERAND_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;

   logic [OPERAND_WIDTH:0]   shifted;
   logic [OPERAND_WIDTH:0]   diff;
   logic                     qbit;

   assign shifted = {rem_ff, dvd_ff[OPERAND_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign qbit    = ~diff[OPERAND_WIDTH];

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
         dvd_in = {dvd_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign qstream.start = start;
   assign qstream.shift = busy_ff;
   assign qstream.qbit  = qbit;
   assign qstream.last  = busy_ff & (cnt_ff == '0);
   assign remainder     = rem_ff;

endmodule

`default_nettype wire

FILE: sv/eeg_coef_lane.sv
// ---------------------------------------------------------------------------
// eeg_coef_lane
// One Bezout coefficient pair; forms quotient * cur by shift-add from the
// divider's bit stream, then steps prev/cur on update.
// ---------------------------------------------------------------------------
`default_nettype none

module eeg_coef_lane
   import eeg_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   load,
   input  wire logic [OPERAND_WIDTH:0] load_prev,
   input  wire logic [OPERAND_WIDTH:0] load_cur,
   input  wire eeg_qstream_type        qstream,
   input  wire logic                   update,
   output logic      [OPERAND_WIDTH:0] coef_prev
);

   logic [OPERAND_WIDTH:0] prev_ff, prev_in;
   logic [OPERAND_WIDTH:0] cur_ff, cur_in;
   logic [OPERAND_WIDTH:0] acc_ff, acc_in;

   always_comb begin
      prev_in = prev_ff;
      cur_in  = cur_ff;
      acc_in  = acc_ff;
      if (load) begin
         prev_in = load_prev;
         cur_in  = load_cur;
      end else if (update) begin
         prev_in = cur_ff;
         cur_in  = prev_ff - acc_ff;
      end
      if (qstream.start) begin
         acc_in = '0;
      end else if (qstream.shift) begin
         acc_in = {acc_ff[OPERAND_WIDTH-1:0], 1'b0} + (qstream.qbit ? cur_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
   end

   assign coef_prev = prev_ff;

endmodule

`default_nettype wire

FILE: sv/extended_euclid_gcd_core.sv
// ---------------------------------------------------------------------------
// extended_euclid_gcd_core
// Extended Euclidean algorithm: gcd, Bezout coefficients and step count,
// one remainder division at a time on a shared serial divider.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | first_operand, second_operand
//   rsp     | out       | rsp_valid/rsp_stall  | gcd, coef_first, coef_second,
//           |           |                      | step_count
//
// Each division step runs through ST_CHECK, which starts the divider, then
// ST_DIV while the divider shifts out its quotient bits, then ST_UPDATE.
// req_stall is high from acceptance until the result is written to the
// output register; a new transaction is taken while a result waits on rsp.
// Synchronous active-high reset clears the sequencer and rsp_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module extended_euclid_gcd_core
   import eeg_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic        [OPERAND_WIDTH-1:0] req_first_operand,
   input  wire logic        [OPERAND_WIDTH-1:0] req_second_operand,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic             [OPERAND_WIDTH-1:0] rsp_gcd,
   output logic signed      [OPERAND_WIDTH:0]   rsp_coef_first,
   output logic signed      [OPERAND_WIDTH:0]   rsp_coef_second,
   output logic             [STEP_WIDTH-1:0]    rsp_step_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE
   } state_type;

   localparam logic [OPERAND_WIDTH:0] COEF_ZERO = '0;
   localparam logic [OPERAND_WIDTH:0] COEF_ONE  = (OPERAND_WIDTH+1)'(1);

   state_type                state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] rem_prev_ff, rem_prev_in;
   logic [OPERAND_WIDTH-1:0] rem_cur_ff, rem_cur_in;
   logic [STEP_WIDTH-1:0]    steps_ff, steps_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] gcd_ff, gcd_in;
   logic [OPERAND_WIDTH:0]   coef_first_ff, coef_first_in;
   logic [OPERAND_WIDTH:0]   coef_second_ff, coef_second_in;
   logic [STEP_WIDTH-1:0]    step_count_ff, step_count_in;

   logic                     accept;
   logic                     div_start;
   logic                     lane_update;
   eeg_qstream_type          qstream;
   logic [OPERAND_WIDTH-1:0] div_rem;
   logic [OPERAND_WIDTH:0]   coef_a_prev;
   logic [OPERAND_WIDTH:0]   coef_b_prev;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid & ~req_stall;
   assign div_start   = (state_ff == ST_CHECK) & (rem_cur_ff != '0);
   assign lane_update = (state_ff == ST_UPDATE);

   eeg_divider #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rem_prev_ff),
      .divisor  (rem_cur_ff),
      .qstream  (qstream),
      .remainder(div_rem)
   );

   eeg_coef_lane #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_lane_a (
      .clock    (clock),
      .load     (accept),
      .load_prev(COEF_ONE),
      .load_cur (COEF_ZERO),
      .qstream  (qstream),
      .update   (lane_update),
      .coef_prev(coef_a_prev)
   );

   eeg_coef_lane #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_lane_b (
      .clock    (clock),
      .load     (accept),
      .load_prev(COEF_ZERO),
      .load_cur (COEF_ONE),
      .qstream  (qstream),
      .update   (lane_update),
      .coef_prev(coef_b_prev)
   );

   always_comb begin
      state_in       = state_ff;
      rem_prev_in    = rem_prev_ff;
      rem_cur_in     = rem_cur_ff;
      steps_in       = steps_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      gcd_in         = gcd_ff;
      coef_first_in  = coef_first_ff;
      coef_second_in = coef_second_ff;
      step_count_in  = step_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rem_prev_in = req_first_operand;
               rem_cur_in  = req_second_operand;
               steps_in    = '0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rem_cur_ff != '0) begin
               state_in = ST_DIV;
            end else if (~rsp_valid_ff | ~rsp_stall) begin
               rsp_valid_in   = 1'b1;
               gcd_in         = rem_prev_ff;
               coef_first_in  = coef_a_prev;
               coef_second_in = coef_b_prev;
               step_count_in  = steps_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (qstream.last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            rem_prev_in = rem_cur_ff;
            rem_cur_in  = div_rem;
            steps_in    = steps_ff + 1'b1;
            state_in    = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rem_prev_ff  <= '0;
         rem_cur_ff   <= '0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_prev_ff  <= rem_prev_in;
         rem_cur_ff   <= rem_cur_in;
         steps_ff     <= steps_in;
      end
      gcd_ff         <= gcd_in;
      coef_first_ff  <= coef_first_in;
      coef_second_ff <= coef_second_in;
      step_count_ff  <= step_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gcd         = gcd_ff;
   assign rsp_coef_first  = $signed(coef_first_ff);
   assign rsp_coef_second = $signed(coef_second_ff);
   assign rsp_step_count  = step_count_ff;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for extended_euclid_gcd_core. Operand pairs go in on the req
// channel and each is checked against a local extended-Euclid predictor for
// gcd, both Bezout coefficients and the division step count. Both channels
// idle and stall at random, with a full-rate stretch and a drain pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import eeg_pkg::*;
();

   localparam int OPERAND_WIDTH     = 32;
   localparam int IDLE_PERCENT      = 17;
   localparam int MAX_REPORTED      = 10;
   localparam int SETTLE_CYCLES     = 100;
   localparam int CYCLE_LIMIT       = 20_000_000;
   localparam logic [31:0] FIB_47   = 32'd2971215073;
   localparam logic [31:0] FIB_46   = 32'd1836311903;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;

   typedef struct packed {
      operand_type                   gcd;
      logic signed [OPERAND_WIDTH:0] coef_first;
      logic signed [OPERAND_WIDTH:0] coef_second;
      logic [STEP_WIDTH-1:0]         step_count;
   } bezout_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   operand_type                   req_first_operand;
   operand_type                   req_second_operand;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   operand_type                   rsp_gcd;
   logic signed [OPERAND_WIDTH:0] rsp_coef_first;
   logic signed [OPERAND_WIDTH:0] rsp_coef_second;
   logic [STEP_WIDTH-1:0]         rsp_step_count;

   bezout_result_type pending_results[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                idle_enable;

   extended_euclid_gcd_core #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gcd            (rsp_gcd),
      .rsp_coef_first     (rsp_coef_first),
      .rsp_coef_second    (rsp_coef_second),
      .rsp_step_count     (rsp_step_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // coefficient arithmetic wraps mod 2^64; final values are exact
   function automatic bezout_result_type predict_bezout(input operand_type first,
                                                        input operand_type second);
      logic [63:0]           r_prev, r_cur, a_prev, a_cur, b_prev, b_cur;
      logic [63:0]           quot, nxt;
      logic [STEP_WIDTH-1:0] steps;
      bezout_result_type     res;
      r_prev = first;
      r_cur  = second;
      a_prev = 64'd1;
      a_cur  = 64'd0;
      b_prev = 64'd0;
      b_cur  = 64'd1;
      steps  = '0;
      while (r_cur != 64'd0) begin
         quot   = r_prev / r_cur;
         nxt    = r_prev - quot * r_cur;
         r_prev = r_cur;
         r_cur  = nxt;
         nxt    = a_prev - quot * a_cur;
         a_prev = a_cur;
         a_cur  = nxt;
         nxt    = b_prev - quot * b_cur;
         b_prev = b_cur;
         b_cur  = nxt;
         steps  = steps + 1'b1;
      end
      res.gcd         = r_prev[OPERAND_WIDTH-1:0];
      res.coef_first  = a_prev[OPERAND_WIDTH:0];
      res.coef_second = b_prev[OPERAND_WIDTH:0];
      res.step_count  = steps;
      return res;
   endfunction

   task automatic send_pair(input operand_type first, input operand_type second);
      if (idle_enable) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_first_operand  <= first;
      req_second_operand <= second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_bezout(first, second));
   endtask

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_zero_operands();
      send_pair('0, '0);
      send_pair('1, '0);
      send_pair('0, '1);
      send_pair(32'd1, '0);
      send_pair('0, 32'd1);
      send_pair(32'd77, '0);
   endtask

   task automatic test_extreme_operands();
      send_pair(32'd1, 32'd1);
      send_pair('1, '1);
      send_pair('1, 32'd1);
      send_pair(32'd1, '1);
      send_pair('1, 32'hFFFF_FFFE);
      send_pair(32'h8000_0000, 32'h4000_0000);
      send_pair(32'h8000_0000, '1);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'd12, 32'd18);
      send_pair(32'd240, 32'd46);
      send_pair(32'd6, 32'd6);
      send_pair(FIB_47, FIB_46);
      send_pair(FIB_46, FIB_47);
      send_pair(32'd4294967291, 32'd4294967279);
   endtask

   task automatic test_random_pairs(input int count);
      operand_type first, second, factor, tmp;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0, 1, 2: begin
               first  = $urandom & ('1 >> $urandom_range(0, OPERAND_WIDTH - 1));
               second = $urandom & ('1 >> $urandom_range(0, OPERAND_WIDTH - 1));
            end
            3, 4: begin
               first  = $urandom;
               second = $urandom;
            end
            5: begin
               factor = $urandom_range(1, 4095);
               first  = factor * ($urandom & 32'h000F_FFFF);
               second = factor * ($urandom & 32'h000F_FFFF);
            end
            6: begin
               first  = $urandom;
               case ($urandom_range(2))
                  0: second = first;
                  1: second = '0;
                  default: begin
                     second = first;
                     first  = '0;
                  end
               endcase
            end
            default: begin
               first  = $urandom;
               second = $urandom;
               if (first > second) begin
                  tmp    = first;
                  first  = second;
                  second = tmp;
               end
            end
         endcase
         send_pair(first, second);
      end
   endtask

   task automatic test_full_rate(input int count);
      idle_enable = 1'b0;
      test_random_pairs(count);
      idle_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      bezout_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected transaction: gcd=%0d coef_first=%0d coef_second=%0d steps=%0d",
                        rsp_gcd, rsp_coef_first, rsp_coef_second, rsp_step_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_gcd !== want.gcd || rsp_coef_first !== want.coef_first ||
                rsp_coef_second !== want.coef_second ||
                rsp_step_count !== want.step_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display({"mismatch: expected gcd=%0d coef_first=%0d coef_second=%0d ",
                            "steps=%0d, got gcd=%0d coef_first=%0d coef_second=%0d steps=%0d"},
                           want.gcd, want.coef_first, want.coef_second, want.step_count,
                           rsp_gcd, rsp_coef_first, rsp_coef_second, rsp_step_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("extended_euclid_gcd_core test failed");
         $finish;
      end
   end

   initial begin
      idle_enable         = 1'b1;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_first_operand  <= '0;
      req_second_operand <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_zero_operands();
      test_extreme_operands();
      wait_all_returned();
      test_random_pairs(800);
      wait_all_returned();
      test_full_rate(500);
      test_random_pairs(680);

      wait_all_returned();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("extended_euclid_gcd_core test passed");
      end else begin
         $display("extended_euclid_gcd_core test failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/eeg_pkg.sv
sv/eeg_divider.sv
sv/eeg_coef_lane.sv
sv/extended_euclid_gcd_core.sv
test/tb_top.sv
